>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the sniffer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, masked while reset is low
`define TES_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included
`define TES_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> src/tes_pkg.sv
// ----------------------------------------------------------------------------
// tes_pkg
// Types, verdict codes, UTF-8 limits and letter tables of the sniffer.
// ----------------------------------------------------------------------------
package tes_pkg;

  // Width of the score fields on the result port
  localparam int unsigned OUT_SCORE_W = 24;

  typedef logic [2:0] verdict_t;

  localparam verdict_t VERDICT_UTF8     = 3'd0;
  localparam verdict_t VERDICT_UTF8_BOM = 3'd1;
  localparam verdict_t VERDICT_CP1250   = 3'd2;
  localparam verdict_t VERDICT_LATIN2   = 3'd3;
  localparam verdict_t VERDICT_UTF16LE  = 3'd4;
  localparam verdict_t VERDICT_UTF16BE  = 3'd5;

  // Byte-order mark bytes
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  // UTF-8 code point limits
  localparam logic [20:0] CP_MIN_2B   = 21'h000080;
  localparam logic [20:0] CP_MIN_3B   = 21'h000800;
  localparam logic [20:0] CP_MIN_4B   = 21'h010000;
  localparam logic [20:0] CP_MAX      = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST  = 21'h00D800;
  localparam logic [20:0] SURR_LAST   = 21'h00DFFF;

  // Open sequence length codes (continuation bytes expected)
  localparam logic [1:0] SEQ_2B = 2'd1;
  localparam logic [1:0] SEQ_3B = 2'd2;
  localparam logic [1:0] SEQ_4B = 2'd3;

  // Control of one byte transaction into the validator
  typedef struct packed {
    logic take;
    logic last;
  } byte_ctl_t;

  // Letter flags for bytes 0x80..0xFF, eight bytes per row, bit i = row base + i
  localparam logic [7:0] CP1250_ROWS [16] = '{
    8'h00, 8'h64, 8'h00, 8'hF4, 8'h00, 8'h00, 8'h08, 8'hC2,
    8'h02, 8'h01, 8'h00, 8'h00, 8'h62, 8'hB7, 8'h1C, 8'h27
  };
  localparam logic [7:0] LATIN2_ROWS [16] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h4A, 8'h6A, 8'hDA,
    8'h02, 8'h01, 8'h00, 8'h00, 8'h62, 8'hB7, 8'h1C, 8'h27
  };

  function automatic logic cp1250_letter(input logic [7:0] b);
    cp1250_letter = b[7] & CP1250_ROWS[b[6:3]][b[2:0]];
  endfunction

  function automatic logic latin2_letter(input logic [7:0] b);
    latin2_letter = b[7] & LATIN2_ROWS[b[6:3]][b[2:0]];
  endfunction

endpackage

>>> src/tes_utf8.sv
// ----------------------------------------------------------------------------
// tes_utf8
// UTF-8 validator: tracks the open sequence and a sticky failure flag.
// ----------------------------------------------------------------------------
module tes_utf8 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        data,
  input  tes_pkg::byte_ctl_t ctl,
  output logic              failed
);
  import tes_pkg::*;

  logic [1:0]  cont_r, cont_nxt;
  logic [1:0]  len_r, len_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic        bad_r, bad_nxt;
  logic        fail_r, fail_nxt;

  // Decode lead byte or fold in a continuation byte, check on completion
  always_comb begin
    cont_nxt = cont_r;
    len_nxt  = len_r;
    acc_nxt  = acc_r;
    bad_nxt  = bad_r;
    fail_nxt = fail_r;
    if (!fail_r) begin
      if (cont_r == 2'd0) begin
        bad_nxt = 1'b0;
        if (!data[7]) begin
          fail_nxt = fail_r;
        end else if (data[7:5] == 3'b110) begin
          cont_nxt = SEQ_2B;
          len_nxt  = SEQ_2B;
          acc_nxt  = {16'd0, data[4:0]};
        end else if (data[7:4] == 4'b1110) begin
          cont_nxt = SEQ_3B;
          len_nxt  = SEQ_3B;
          acc_nxt  = {17'd0, data[3:0]};
        end else if (data[7:3] == 5'b11110) begin
          cont_nxt = SEQ_4B;
          len_nxt  = SEQ_4B;
          acc_nxt  = {18'd0, data[2:0]};
        end else begin
          fail_nxt = 1'b1;
        end
      end else begin
        if (data[7:6] != 2'b10) begin
          bad_nxt = 1'b1;
        end
        acc_nxt  = {acc_r[14:0], data[5:0]};
        cont_nxt = cont_r - 2'd1;
        if (cont_nxt == 2'd0) begin
          if (bad_nxt) fail_nxt = 1'b1;
          if (len_r == SEQ_2B && acc_nxt < CP_MIN_2B) fail_nxt = 1'b1;
          if (len_r == SEQ_3B && acc_nxt < CP_MIN_3B) fail_nxt = 1'b1;
          if (len_r == SEQ_4B && acc_nxt < CP_MIN_4B) fail_nxt = 1'b1;
          if (acc_nxt > CP_MAX) fail_nxt = 1'b1;
          if (acc_nxt >= SURR_FIRST && acc_nxt <= SURR_LAST) fail_nxt = 1'b1;
        end
      end
    end
  end

  assign failed = fail_nxt;

  // Advance on each byte, clear at the end of a sample
  always_ff @(posedge clk) begin
    if (!rst_n || (ctl.take && ctl.last)) begin
      cont_r <= 2'd0;
      len_r  <= 2'd0;
      acc_r  <= 21'd0;
      bad_r  <= 1'b0;
      fail_r <= 1'b0;
    end else if (ctl.take) begin
      cont_r <= cont_nxt;
      len_r  <= len_nxt;
      acc_r  <= acc_nxt;
      bad_r  <= bad_nxt;
      fail_r <= fail_nxt;
    end
  end

endmodule

>>> src/text_encoding_sniffer.sv
// ----------------------------------------------------------------------------
// text_encoding_sniffer
// Guesses the encoding of a byte stream sample: BOM, UTF-8, cp1250, Latin-2.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except while a stalled result holds a last byte in the input register.
// The verdict passes from the input register to the result register after the last byte is accepted.
// A stalled result blocks only a last byte, which waits in the input register and stalls the input.
// Reset (synchronous, active low) empties both registers and starts a new sample.
// Each sample's state clears itself when its last byte is processed.
module text_encoding_sniffer #(
  parameter int unsigned SCORE_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_sample_byte,
  input  logic                in_is_last,
  output logic                out_valid,
  input  logic                out_stall,
  output tes_pkg::verdict_t   out_verdict,
  output logic [23:0]         out_score_cp1250,
  output logic [23:0]         out_score_latin2
);
  import tes_pkg::*;

  localparam logic [SCORE_BITS-1:0] SCORE_TOP = {SCORE_BITS{1'b1}};

  logic                  s1_valid_r;
  logic [7:0]            s1_byte_r;
  logic                  s1_last_r;
  logic                  s1_go;
  logic                  s1_free;

  logic [1:0]            seen_r, seen_nxt;
  logic [7:0]            head0_r, head1_r, head2_r;
  logic [7:0]            head0_nxt, head1_nxt, head2_nxt;
  logic [SCORE_BITS-1:0] cp_cnt_r, cp_cnt_nxt;
  logic [SCORE_BITS-1:0] l2_cnt_r, l2_cnt_nxt;

  byte_ctl_t             ctl;
  logic                  utf8_fail;
  verdict_t              verdict;

  logic                  out_valid_r;
  verdict_t              out_verdict_r;
  logic [23:0]           out_cp_r;
  logic [23:0]           out_l2_r;

  // Process the held byte unless it ends a sample and the result is blocked
  assign s1_go    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign s1_free  = !s1_valid_r || s1_go;
  assign in_stall = !s1_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_byte_r <= in_sample_byte;
      s1_last_r <= in_is_last;
    end
  end

  assign ctl.take = s1_go;
  assign ctl.last = s1_last_r;

  tes_utf8 u_utf8 (
    .clk    (clk),
    .rst_n  (rst_n),
    .data   (s1_byte_r),
    .ctl    (ctl),
    .failed (utf8_fail)
  );

  // Capture the first three bytes of the sample
  always_comb begin
    head0_nxt = head0_r;
    head1_nxt = head1_r;
    head2_nxt = head2_r;
    seen_nxt  = seen_r;
    if (seen_r != 2'd3) begin
      seen_nxt = seen_r + 2'd1;
      if (seen_r == 2'd0) head0_nxt = s1_byte_r;
      if (seen_r == 2'd1) head1_nxt = s1_byte_r;
      if (seen_r == 2'd2) head2_nxt = s1_byte_r;
    end
  end

  // Bump the saturating letter scores
  always_comb begin
    cp_cnt_nxt = cp_cnt_r;
    l2_cnt_nxt = l2_cnt_r;
    if (cp1250_letter(s1_byte_r) && cp_cnt_r != SCORE_TOP) begin
      cp_cnt_nxt = cp_cnt_r + SCORE_BITS'(1);
    end
    if (latin2_letter(s1_byte_r) && l2_cnt_r != SCORE_TOP) begin
      l2_cnt_nxt = l2_cnt_r + SCORE_BITS'(1);
    end
  end

  // Pick the verdict: marks first, then UTF-8, then the score contest
  always_comb begin
    if (seen_nxt == 2'd3 && head0_nxt == BOM_EF && head1_nxt == BOM_BB &&
        head2_nxt == BOM_BF) begin
      verdict = VERDICT_UTF8_BOM;
    end else if (seen_nxt >= 2'd2 && head0_nxt == BOM_FF && head1_nxt == BOM_FE) begin
      verdict = VERDICT_UTF16LE;
    end else if (seen_nxt >= 2'd2 && head0_nxt == BOM_FE && head1_nxt == BOM_FF) begin
      verdict = VERDICT_UTF16BE;
    end else if (!utf8_fail) begin
      verdict = VERDICT_UTF8;
    end else if (l2_cnt_nxt > cp_cnt_nxt) begin
      verdict = VERDICT_LATIN2;
    end else begin
      verdict = VERDICT_CP1250;
    end
  end

  // Sample state: advance per byte, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_last_r)) begin
      seen_r   <= 2'd0;
      head0_r  <= 8'd0;
      head1_r  <= 8'd0;
      head2_r  <= 8'd0;
      cp_cnt_r <= '0;
      l2_cnt_r <= '0;
    end else if (s1_go) begin
      seen_r   <= seen_nxt;
      head0_r  <= head0_nxt;
      head1_r  <= head1_nxt;
      head2_r  <= head2_nxt;
      cp_cnt_r <= cp_cnt_nxt;
      l2_cnt_r <= l2_cnt_nxt;
    end
  end

  // Result register: load on a last byte, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_verdict_r <= verdict;
      out_cp_r      <= OUT_SCORE_W'(cp_cnt_nxt);
      out_l2_r      <= OUT_SCORE_W'(l2_cnt_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = out_verdict_r;
  assign out_score_cp1250 = out_cp_r;
  assign out_score_latin2 = out_l2_r;

endmodule

>>> src/tes_checker.sv
// ----------------------------------------------------------------------------
// tes_checker
// Port-level checks of the sniffer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tes_checker #(
  parameter int unsigned SCORE_BITS = 24
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input tes_pkg::verdict_t out_verdict,
  input logic [23:0]       out_score_cp1250,
  input logic [23:0]       out_score_latin2
);
  import tes_pkg::*;

  localparam logic FULL_SCORES = (SCORE_BITS <= OUT_SCORE_W);

  // Latin-2 wins only on a strictly higher score
  `TES_ASSERT(a_latin2_wins, clk, rst_n, (out_valid && out_verdict == VERDICT_LATIN2 && FULL_SCORES) |-> (out_score_latin2 > out_score_cp1250))

  // cp1250 verdict never shows a higher Latin-2 score
  `TES_ASSERT(a_cp1250_wins, clk, rst_n, (out_valid && out_verdict == VERDICT_CP1250 && FULL_SCORES) |-> (out_score_latin2 <= out_score_cp1250))

  // Hold a stalled result
  `TES_ASSERT(a_out_hold, clk, rst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_verdict) && $stable(out_score_cp1250) && $stable(out_score_latin2)))

  // Stall the input only behind a blocked result
  `TES_ASSERT(a_in_stall_cause, clk, rst_n, in_stall |-> (out_valid && out_stall))

  // Reset empties the result register
  `TES_ASSERT_NR(a_reset_empty, clk, (!rst_n) |=> (!out_valid))

endmodule

bind text_encoding_sniffer tes_checker #(.SCORE_BITS(SCORE_BITS)) u_tes_checker (.*);
